// ===== rtl/qnl_pkg.sv =====
// shared widths, types and stage counts for the quaternion nlerp pipeline
`default_nettype none

package qnl_pkg;

    localparam int COMP_W       = 16;
    localparam int LANES        = 4;
    localparam int BLEND_W      = 15;
    localparam logic [BLEND_W-1:0] FRAC_ONE = 15'd16384;
    localparam logic signed [COMP_W-1:0] RES_MAX = 16'sd16384;

    localparam int PROD_W       = 2 * COMP_W + 1;
    localparam int MAG_W        = 30;
    localparam int SQ_W         = 2 * MAG_W + 2;
    localparam int ROOT_W       = MAG_W + 1;
    localparam int QUO_W        = 15;
    localparam int DEN_W        = ROOT_W + 1;
    localparam int NUM_W        = MAG_W + QUO_W + 1;

    localparam int BLEND_STAGES = 4;
    localparam int SHIFT_STEPS  = 5;
    localparam int NORM_STAGES  = SHIFT_STEPS + 3;

    typedef logic [LANES-1:0][COMP_W-1:0] quat_t;
    typedef logic [LANES-1:0][MAG_W-1:0]  mag_vec_t;
    typedef logic [LANES-1:0][QUO_W-1:0]  quo_vec_t;

    typedef struct packed {
        mag_vec_t          mag;
        logic [LANES-1:0]  neg;
        logic              zero;
    } norm_t;

    typedef struct packed {
        logic [LANES-1:0]  neg;
        logic              zero;
    } sign_t;

    typedef struct packed {
        quat_t  r;
        logic   zero;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/qnl_blend.sv =====
// dot-product sign, shortest-path flip and exact blend, four stages
`default_nettype none

module qnl_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  qnl_pkg::quat_t                in_p,
    input  qnl_pkg::quat_t                in_q,
    input  logic [qnl_pkg::BLEND_W-1:0]   in_t,
    input  logic                          in_sp,
    output logic                          out_valid,
    output qnl_pkg::mag_vec_t             out_mag,
    output logic [qnl_pkg::LANES-1:0]     out_neg
);
    import qnl_pkg::*;

    logic [BLEND_STAGES-1:0]       valid_reg, valid_next;

    quat_t                         p1_reg, q1_reg;
    logic [BLEND_W-1:0]            t1_reg, t1_next;
    logic                          sp1_reg;
    logic signed [2*COMP_W-1:0]    dp_reg [LANES];
    logic signed [2*COMP_W-1:0]    dp_next [LANES];

    quat_t                         p2_reg;
    logic [BLEND_W-1:0]            t2_reg;
    logic signed [COMP_W:0]        q2_reg [LANES];
    logic signed [COMP_W:0]        q2_next [LANES];
    logic signed [2*COMP_W+1:0]    dsum;

    logic [BLEND_W-1:0]            wp_w;
    logic signed [PROD_W-1:0]      wp_reg [LANES];
    logic signed [PROD_W-1:0]      wp_next [LANES];
    logic signed [PROD_W-1:0]      wq_reg [LANES];
    logic signed [PROD_W-1:0]      wq_next [LANES];

    logic signed [PROD_W:0]        v [LANES];
    mag_vec_t                      mag_reg, mag_next;
    logic [LANES-1:0]              neg_reg, neg_next;

    always_comb
    begin
        valid_next = {valid_reg[BLEND_STAGES-2:0], in_valid};
        t1_next    = (in_t > FRAC_ONE) ? FRAC_ONE : in_t;
        for (int i = 0; i < LANES; i++)
        begin
            dp_next[i] = (2*COMP_W)'($signed(in_p[i])) * (2*COMP_W)'($signed(in_q[i]));
        end

        dsum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dsum = dsum + (2*COMP_W+2)'(dp_reg[i]);
        end
        // negate q only when shortest path is requested and the dot product is strictly negative
        for (int i = 0; i < LANES; i++)
        begin
            if (sp1_reg && dsum[2*COMP_W+1])
                q2_next[i] = -((COMP_W+1)'($signed(q1_reg[i])));
            else
                q2_next[i] = (COMP_W+1)'($signed(q1_reg[i]));
        end

        wp_w = FRAC_ONE - t2_reg;
        for (int i = 0; i < LANES; i++)
        begin
            wp_next[i] = PROD_W'($signed({1'b0, wp_w})) * PROD_W'($signed(p2_reg[i]));
            wq_next[i] = PROD_W'($signed({1'b0, t2_reg})) * PROD_W'(q2_reg[i]);
        end

        for (int i = 0; i < LANES; i++)
        begin
            v[i]        = (PROD_W+1)'(wp_reg[i]) + (PROD_W+1)'(wq_reg[i]);
            neg_next[i] = v[i][PROD_W];
            mag_next[i] = v[i][PROD_W] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= in_p;
            q1_reg  <= in_q;
            t1_reg  <= t1_next;
            sp1_reg <= in_sp;
            p2_reg  <= p1_reg;
            t2_reg  <= t1_reg;
            for (int i = 0; i < LANES; i++)
            begin
                dp_reg[i] <= dp_next[i];
                q2_reg[i] <= q2_next[i];
                wp_reg[i] <= wp_next[i];
                wq_reg[i] <= wq_next[i];
            end
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign out_valid = valid_reg[BLEND_STAGES-1];
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;

endmodule

`default_nettype wire

// ===== rtl/qnl_norm.sv =====
// block normalization by staged left shifts, then squares and their sum
`default_nettype none

module qnl_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  qnl_pkg::mag_vec_t             in_mag,
    input  logic [qnl_pkg::LANES-1:0]     in_neg,
    output logic                          out_valid,
    output qnl_pkg::norm_t                out_vec,
    output logic [qnl_pkg::SQ_W-1:0]      out_sum
);
    import qnl_pkg::*;

    logic [NORM_STAGES-1:0]   valid_reg, valid_next;

    logic [MAG_W-1:0]         mx_a, mx_b, m_in;
    norm_t                    vec_reg  [SHIFT_STEPS+1];
    norm_t                    vec_next [SHIFT_STEPS+1];
    logic [MAG_W-1:0]         m_reg    [SHIFT_STEPS+1];
    logic [MAG_W-1:0]         m_next   [SHIFT_STEPS+1];

    logic [2*MAG_W-1:0]       sq_reg  [LANES];
    logic [2*MAG_W-1:0]       sq_next [LANES];
    norm_t                    vsq_reg, vout_reg;
    logic [SQ_W-1:0]          sum_reg, sum_next;

    always_comb
    begin
        valid_next = {valid_reg[NORM_STAGES-2:0], in_valid};

        mx_a = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
        mx_b = (in_mag[2] > in_mag[3]) ? in_mag[2] : in_mag[3];
        m_in = (mx_a > mx_b) ? mx_a : mx_b;

        vec_next[0].mag  = in_mag;
        vec_next[0].neg  = in_neg;
        vec_next[0].zero = (m_in == '0);
        m_next[0]        = m_in;

        // shift by 16, 8, 4, 2, 1 while the maximum stays at or below 2^29
        for (int k = 0; k < SHIFT_STEPS; k++)
        begin
            vec_next[k+1] = vec_reg[k];
            m_next[k+1]   = m_reg[k];
            if (m_reg[k] <= (MAG_W'(1) << (MAG_W - 1 - (1 << (SHIFT_STEPS - 1 - k)))))
            begin
                m_next[k+1] = m_reg[k] << (1 << (SHIFT_STEPS - 1 - k));
                for (int i = 0; i < LANES; i++)
                begin
                    vec_next[k+1].mag[i] = vec_reg[k].mag[i] << (1 << (SHIFT_STEPS - 1 - k));
                end
            end
        end

        for (int i = 0; i < LANES; i++)
        begin
            sq_next[i] = vec_reg[SHIFT_STEPS].mag[i] * vec_reg[SHIFT_STEPS].mag[i];
        end

        sum_next = SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]) + SQ_W'(sq_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= SHIFT_STEPS; k++)
            begin
                vec_reg[k] <= vec_next[k];
                m_reg[k]   <= m_next[k];
            end
            for (int i = 0; i < LANES; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            vsq_reg  <= vec_reg[SHIFT_STEPS];
            vout_reg <= vsq_reg;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid = valid_reg[NORM_STAGES-1];
    assign out_vec   = vout_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/qnl_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none

module qnl_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  qnl_pkg::norm_t                in_vec,
    input  logic [qnl_pkg::SQ_W-1:0]      in_sum,
    output logic                          out_valid,
    output qnl_pkg::norm_t                out_vec,
    output logic [qnl_pkg::ROOT_W-1:0]    out_root
);
    import qnl_pkg::*;

    logic [ROOT_W-1:0]   valid_reg, valid_next;

    logic [SQ_W-1:0]     rem_src  [ROOT_W];
    logic [ROOT_W-1:0]   root_src [ROOT_W];
    norm_t               vec_src  [ROOT_W];
    logic [SQ_W-1:0]     rem_reg  [ROOT_W];
    logic [SQ_W-1:0]     rem_next [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [ROOT_W-1:0]   root_next[ROOT_W];
    norm_t               vec_reg  [ROOT_W];
    logic [SQ_W-1:0]     trial;

    always_comb
    begin
        valid_next = {valid_reg[ROOT_W-2:0], in_valid};

        rem_src[0]  = in_sum;
        root_src[0] = '0;
        vec_src[0]  = in_vec;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            vec_src[k]  = vec_reg[k-1];
        end

        // stage k decides root bit ROOT_W-1-k: (root + 2^b)^2 <= S
        trial = '0;
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial = (SQ_W'(root_src[k]) << (ROOT_W - k))
                  | (SQ_W'(1) << (2 * (ROOT_W - 1 - k)));
            rem_next[k]  = rem_src[k];
            root_next[k] = root_src[k];
            if (rem_src[k] >= trial)
            begin
                rem_next[k]  = rem_src[k] - trial;
                root_next[k] = root_src[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                vec_reg[k]  <= vec_src[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_vec   = vec_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/qnl_div.sv =====
// four-lane restoring divider, one quotient bit per stage, round half up
`default_nettype none

module qnl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  qnl_pkg::norm_t                in_vec,
    input  logic [qnl_pkg::ROOT_W-1:0]    in_root,
    output logic                          out_valid,
    output qnl_pkg::quo_vec_t             out_quo,
    output qnl_pkg::sign_t                out_sign
);
    import qnl_pkg::*;

    logic [QUO_W-1:0]              valid_reg, valid_next;

    logic [LANES-1:0][NUM_W-1:0]   rem_src  [QUO_W];
    logic [DEN_W-1:0]              den_src  [QUO_W];
    quo_vec_t                      quo_src  [QUO_W];
    sign_t                         sign_src [QUO_W];
    logic [LANES-1:0][NUM_W-1:0]   rem_reg  [QUO_W];
    logic [LANES-1:0][NUM_W-1:0]   rem_next [QUO_W];
    logic [DEN_W-1:0]              den_reg  [QUO_W];
    quo_vec_t                      quo_reg  [QUO_W];
    quo_vec_t                      quo_next [QUO_W];
    sign_t                         sign_reg [QUO_W];
    logic [NUM_W-1:0]              dsh;

    always_comb
    begin
        valid_next = {valid_reg[QUO_W-2:0], in_valid};

        // numerator a*2^15 + L over 2L
        for (int i = 0; i < LANES; i++)
        begin
            rem_src[0][i] = (NUM_W'(in_vec.mag[i]) << QUO_W) + NUM_W'(in_root);
        end
        den_src[0]       = {in_root, 1'b0};
        quo_src[0]       = '0;
        sign_src[0].neg  = in_vec.neg;
        sign_src[0].zero = in_vec.zero;
        for (int k = 1; k < QUO_W; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            den_src[k]  = den_reg[k-1];
            quo_src[k]  = quo_reg[k-1];
            sign_src[k] = sign_reg[k-1];
        end

        dsh = '0;
        for (int k = 0; k < QUO_W; k++)
        begin
            dsh         = NUM_W'(den_src[k]) << (QUO_W - 1 - k);
            rem_next[k] = rem_src[k];
            quo_next[k] = quo_src[k];
            for (int i = 0; i < LANES; i++)
            begin
                if (rem_src[k][i] >= dsh)
                begin
                    rem_next[k][i] = rem_src[k][i] - dsh;
                    quo_next[k][i] = quo_src[k][i] | (QUO_W'(1) << (QUO_W - 1 - k));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_src[k];
                quo_reg[k]  <= quo_next[k];
                sign_reg[k] <= sign_src[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_sign  = sign_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/quaternion_nlerp.sv =====
// quaternion nlerp, optionally along the shortest path, top level with output skid stage
//
//  channel   dir  fields (lowest bit up)
//  s_axis    in   tdata: p_x p_y p_z p_w q_x q_y q_z q_w blend pad; tuser: shortest_path
//  m_axis    out  tdata: r_x r_y r_z r_w; tuser: zero_length
//
//  one item per cycle while the skid entry is empty
//  the pipeline runs through blend, normalization, the 31-stage square root and the 15-stage divider
//  an output register plus one skid entry; input stalls only when the skid is full
//  the whole pipeline holds while stalled, valid bits travel with each item
//  reset clears valid bits only
`default_nettype none

module quaternion_nlerp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // p_x, p_y, p_z, p_w, q_x, q_y, q_z, q_w, blend, zero pad
    input  logic [143:0]  s_axis_tdata,
    // shortest_path
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // r_x, r_y, r_z, r_w
    output logic [63:0]   m_axis_tdata,
    // zero_length
    output logic [0:0]    m_axis_tuser
);
    import qnl_pkg::*;

    logic                 en;
    quat_t                in_p, in_q;
    logic [BLEND_W-1:0]   in_t;

    logic                 bl_valid;
    mag_vec_t             bl_mag;
    logic [LANES-1:0]     bl_neg;

    logic                 nm_valid;
    norm_t                nm_vec;
    logic [SQ_W-1:0]      nm_sum;

    logic                 sq_valid;
    norm_t                sq_vec;
    logic [ROOT_W-1:0]    sq_root;

    logic                 dv_valid;
    quo_vec_t             dv_quo;
    sign_t                dv_sign;

    res_t                 res;
    logic                 load_out;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    res_t                 out_data_reg, out_data_next;
    res_t                 skid_data_reg, skid_data_next;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    assign in_p = s_axis_tdata[LANES*COMP_W-1:0];
    assign in_q = s_axis_tdata[2*LANES*COMP_W-1:LANES*COMP_W];
    assign in_t = s_axis_tdata[2*LANES*COMP_W +: BLEND_W];

    qnl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_p      (in_p),
        .in_q      (in_q),
        .in_t      (in_t),
        .in_sp     (s_axis_tuser[0]),
        .out_valid (bl_valid),
        .out_mag   (bl_mag),
        .out_neg   (bl_neg)
    );

    qnl_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bl_valid),
        .in_mag    (bl_mag),
        .in_neg    (bl_neg),
        .out_valid (nm_valid),
        .out_vec   (nm_vec),
        .out_sum   (nm_sum)
    );

    qnl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .in_vec    (nm_vec),
        .in_sum    (nm_sum),
        .out_valid (sq_valid),
        .out_vec   (sq_vec),
        .out_root  (sq_root)
    );

    qnl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_vec    (sq_vec),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sign  (dv_sign)
    );

    // quotient never exceeds 1.0, so sign application cannot overflow
    always_comb
    begin
        res.zero = dv_sign.zero;
        for (int i = 0; i < LANES; i++)
        begin
            if (dv_sign.zero)
                res.r[i] = '0;
            else if (dv_sign.neg[i])
                res.r[i] = -COMP_W'(dv_quo[i]);
            else
                res.r[i] = COMP_W'(dv_quo[i]);
        end
    end

    always_comb
    begin
        load_out        = !out_valid_reg || m_axis_tready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = res;
                out_valid_next = dv_valid;
            end
        end
        else if (dv_valid && !skid_valid_reg)
        begin
            // output held, park the finished item
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg.r;
    assign m_axis_tuser[0] = out_data_reg.zero;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a valid output");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("zero-length result carries nonzero components");

    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[15:0])  <= RES_MAX && $signed(m_axis_tdata[15:0])  >= -RES_MAX &&
             $signed(m_axis_tdata[31:16]) <= RES_MAX && $signed(m_axis_tdata[31:16]) >= -RES_MAX &&
             $signed(m_axis_tdata[47:32]) <= RES_MAX && $signed(m_axis_tdata[47:32]) >= -RES_MAX &&
             $signed(m_axis_tdata[63:48]) <= RES_MAX && $signed(m_axis_tdata[63:48]) >= -RES_MAX))
        else $error("normalized component exceeds unit magnitude");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the quaternion nlerp stream block
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qnl_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic [63:0] r;
        logic        zero;
    } interp_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    interp_t expected_q[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_cycles = 0;
    int      cycle_count = 0;

    quaternion_nlerp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic interp_t predict_nlerp(logic [143:0] data, logic sp);
        interp_t         res;
        longint          p[4];
        longint          q[4];
        longint          v[4];
        longint          dot;
        longint unsigned a[4];
        longint unsigned m;
        longint unsigned s;
        longint unsigned l;
        longint          r;
        longint          t;
        for (int i = 0; i < 4; i++)
        begin
            p[i] = longint'($signed(data[16*i +: 16]));
            q[i] = longint'($signed(data[64 + 16*i +: 16]));
        end
        t = longint'(data[128 +: 15]);
        if (t > 16384)
            t = 16384;
        // products fit easily in 64 bits at 16-bit components
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += p[i] * q[i];
        if (sp && dot < 0)
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
        m = 0;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = (16384 - t) * p[i] + t * q[i];
            a[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (a[i] > m)
                m = a[i];
        end
        res.r = '0;
        res.zero = 1'b0;
        if (m == 0)
        begin
            res.zero = 1'b1;
            return res;
        end
        while (m > (64'd1 << 29))
        begin
            m = m >> 1;
            for (int i = 0; i < 4; i++)
                a[i] = a[i] >> 1;
        end
        while (m <= (64'd1 << 28))
        begin
            m = m << 1;
            for (int i = 0; i < 4; i++)
                a[i] = a[i] << 1;
        end
        s = 0;
        for (int i = 0; i < 4; i++)
            s += a[i] * a[i];
        l = int_sqrt(s);
        for (int i = 0; i < 4; i++)
        begin
            r = longint'(((a[i] << 15) + l) / (2 * l));
            if (r > 32767)
                r = (v[i] < 0) ? 32768 : 32767;
            if (v[i] < 0)
                r = -r;
            res.r[16*i +: 16] = r[15:0];
        end
        return res;
    endfunction

    // leaves tvalid high after the transfer so the next item can follow at once
    task automatic send_item(logic [15:0] pc[4], logic [15:0] qc[4], logic [14:0] t,
                             logic sp);
        logic [143:0] d;
        d = '0;
        for (int i = 0; i < 4; i++)
        begin
            d[16*i +: 16] = pc[i];
            d[64 + 16*i +: 16] = qc[i];
        end
        d[128 +: 15] = t;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= sp;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_q.push_back(predict_nlerp(d, sp));
        @(negedge clk);
    endtask

    task automatic send_scaled(logic [15:0] a, logic [15:0] b, logic [14:0] t, logic sp);
        logic [15:0] pc[4];
        logic [15:0] qc[4];
        for (int i = 0; i < 4; i++)
        begin
            pc[i] = a;
            qc[i] = b;
        end
        send_item(pc, qc, t, sp);
    endtask

    task automatic send_random(bit well_formed);
        logic [15:0] pc[4];
        logic [15:0] qc[4];
        logic [14:0] t;
        for (int i = 0; i < 4; i++)
        begin
            pc[i] = $urandom;
            qc[i] = $urandom;
            // mostly components in the range -8192 to 8192
            if (well_formed)
            begin
                pc[i] = $signed(16'($urandom_range(16384))) - 16'sd8192;
                qc[i] = $signed(16'($urandom_range(16384))) - 16'sd8192;
            end
        end
        t = (well_formed || $urandom_range(1)) ? 15'($urandom_range(16384)) : 15'($urandom);
        send_item(pc, qc, t, 1'($urandom));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    task automatic test_extremes();
        send_scaled(16'h8000, 16'h8000, 15'd0, 1'b1);
        send_scaled(16'h7fff, 16'h8000, 15'd8192, 1'b1);
        send_scaled(16'h7fff, 16'h8000, 15'd8192, 1'b0);
        send_scaled(16'h8000, 16'h7fff, 15'd16384, 1'b1);
        send_scaled(16'h7fff, 16'h7fff, 15'h7fff, 1'b0);
        send_scaled(16'h0001, 16'hffff, 15'd1, 1'b0);
        send_scaled(16'hffff, 16'h0001, 15'd16383, 1'b1);
    endtask

    task automatic test_special_cases();
        logic [15:0] pc[4];
        logic [15:0] qc[4];
        // zero-length blend, both zero and cancelling halves
        send_scaled(16'h0000, 16'h0000, 15'd5000, 1'b1);
        send_scaled(16'h4000, 16'hc000, 15'd8192, 1'b0);
        // blend above one clamps to one
        send_scaled(16'h1234, 16'h2000, 15'd20000, 1'b0);
        send_scaled(16'h1234, 16'h2000, 15'd16385, 1'b1);
        // zero dot product leaves q alone
        pc = '{16'h4000, 16'h0000, 16'h0000, 16'h0000};
        qc = '{16'h0000, 16'h4000, 16'h0000, 16'h0000};
        send_item(pc, qc, 15'd8192, 1'b1);
        // one dominant lane normalizes to unit magnitude
        pc = '{16'h8000, 16'h0000, 16'h0000, 16'h0000};
        qc = '{16'h8000, 16'h0000, 16'h0000, 16'h0000};
        send_item(pc, qc, 15'd100, 1'b1);
        pc = '{16'h0000, 16'h0000, 16'h0000, 16'h0001};
        send_item(pc, pc, 15'd0, 1'b0);
        wait_drain();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < count; n++)
            send_random($urandom_range(99) < 80);
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        for (int n = 0; n < 100; n++)
            send_random(1'b1);
        wait_drain();
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer r=%h zero=%b", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                interp_t e;
                e = expected_q.pop_front();
                if (e.r !== m_axis_tdata || e.zero !== m_axis_tuser[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r=%h zero=%b got r=%h zero=%b",
                                 e.r, e.zero, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_special_cases();
        test_random(200, 20, 67);
        test_random(200, 67, 20);
        test_random(150, 0, 0);
        test_backpressure();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire

// ===== quaternion_nlerp.f =====
rtl/qnl_pkg.sv
rtl/qnl_blend.sv
rtl/qnl_norm.sv
rtl/qnl_sqrt.sv
rtl/qnl_div.sv
rtl/quaternion_nlerp.sv
bench/testbench.sv
